[hdl/ordered_value_list_table_defines.svh]
// assertion macros for the ordered value list table
`ifndef ORDERED_VALUE_LIST_TABLE_DEFINES_SVH
`define ORDERED_VALUE_LIST_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OVLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define OVLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ovlt_pkg.sv]
// shared types and constants for the ordered value list table
package ovlt_pkg;

  localparam int CAP   = 16;
  localparam int VAL_W = 32;
  localparam int POS_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] position;
    logic [4:0] count;
  } rsp_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_t;

endpackage

[hdl/ovlt_ctrl.sv]
// controller state machine for the ordered value list table
module ovlt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_stall,
  output logic            in_stall,
  output logic            out_valid,
  output ovlt_pkg::ctrl_t ctrl
);
  import ovlt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // result register can take a new result this cycle
  assign slot_free = !out_valid_r || !out_stall;

  // datapath commands
  always_comb begin
    ctrl.load   = (state_r == S_IDLE) && in_valid;
    ctrl.commit = (state_r == S_EXEC) && slot_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  assign out_valid_nxt = ctrl.commit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hdl/ovlt_datapath.sv]
// entry row with compare cells, neighbour shifts and result register
module ovlt_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  ovlt_pkg::ctrl_t ctrl,
  input  ovlt_pkg::req_t  in_data,
  output ovlt_pkg::rsp_t  out_data
);
  import ovlt_pkg::*;

  req_t             req_r;
  logic [VAL_W-1:0] entry_r   [CAP];
  logic [VAL_W-1:0] entry_nxt [CAP];
  logic [CNT_W-1:0] count_r, count_nxt;
  rsp_t             rsp_r, rsp_nxt;

  logic [VAL_W-1:0] key;
  logic [CAP-1:0]   match_vec;
  logic [CAP-1:0]   first_oh;
  logic [CAP-1:0]   from_hit;
  logic [POS_W-1:0] hit_pos;
  logic             hit;
  logic             full;

  // request value sign-extended or cut to the entry width
  assign key = VAL_W'(req_r.value);

  // one compare cell per live entry
  always_comb begin
    for (int k = 0; k < CAP; k++) begin
      match_vec[k] = (CNT_W'(k) < count_r) && (entry_r[k] == key);
    end
  end

  // first match from the head, and the entries at or after it
  assign first_oh = match_vec & (~match_vec + 1'b1);
  assign from_hit = ~(first_oh - 1'b1);
  assign hit      = |match_vec;
  assign full     = (count_r == CNT_W'(CAP));

  always_comb begin
    hit_pos = '0;
    for (int k = 0; k < CAP; k++) begin
      if (first_oh[k]) hit_pos = hit_pos | POS_W'(k);
    end
  end

  // command decode
  always_comb begin
    for (int k = 0; k < CAP; k++) entry_nxt[k] = entry_r[k];
    count_nxt        = count_r;
    rsp_nxt.status   = ST_OK;
    rsp_nxt.position = '0;
    unique case (req_r.cmd)
      CMD_INSERT: begin
        if (full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          entry_nxt[0] = key;
          for (int k = 1; k < CAP; k++) entry_nxt[k] = entry_r[k-1];
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_SEARCH: begin
        if (hit) rsp_nxt.position = 4'(hit_pos);
        else     rsp_nxt.status   = ST_NOT_FOUND;
      end
      CMD_REMOVE: begin
        if (hit) begin
          rsp_nxt.position = 4'(hit_pos);
          for (int k = 0; k < CAP - 1; k++) begin
            if (from_hit[k]) entry_nxt[k] = entry_r[k+1];
          end
          count_nxt = count_r - 1'b1;
        end else begin
          rsp_nxt.status = ST_NOT_FOUND;
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: count_nxt = count_r;
    endcase
    rsp_nxt.count = 5'(count_nxt);
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (ctrl.load)   req_r <= in_data;
    if (ctrl.commit) rsp_r <= rsp_nxt;
  end

  // entry row
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      for (int k = 0; k < CAP; k++) entry_r[k] <= entry_nxt[k];
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.commit) begin
      count_r <= count_nxt;
    end
  end

  assign out_data = rsp_r;

endmodule

[hdl/ordered_value_list_table.sv]
// top level of the ordered value list table
//
// Keeps up to 16 signed 32-bit values, newest at the head, in a row of entry
// registers with a compare cell on each entry. Each request (insert at head,
// search, remove first match, clear) gives one result with status, position
// of the first match from the head, and the count afterwards. A request is first
// captured in a request register; then every entry is compared and the row
// shifts towards or away from the head. A new request is taken while the
// previous result still waits; a stalled result register holds the update
// cycle until it drains. No clearing pass is needed after reset.
`include "ordered_value_list_table_defines.svh"

module ordered_value_list_table (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ovlt_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ovlt_pkg::rsp_t out_data
);
  import ovlt_pkg::*;

  ctrl_t ctrl;

  // controller
  ovlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  // datapath
  ovlt_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // checks
  `OVLT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted request did not block input")
  `OVLT_ASSERT_NEXT(a_commit_shows_result, ctrl.commit, out_valid, "committed result not presented")
  `OVLT_ASSERT_NOW(a_count_bound, out_valid, out_data.count <= 5'(CAP), "count beyond capacity")
  `OVLT_ASSERT_NOW(a_full_means_cap, out_valid && out_data.status == ST_FULL, out_data.count == 5'(CAP), "full reported below capacity")

endmodule
